[sv/irpfd_pkg.sv]
// ----------------------------------------------------------------------------
// irpfd_pkg
// Shared constants, register indexes and types of the IR pulse frame decoder.
// ----------------------------------------------------------------------------
package irpfd_pkg;

  // Depth of the duration store.
  localparam int PULSE_SLOTS = 128;
  localparam int ADDR_W      = $clog2(PULSE_SLOTS);
  // The fill index must be able to hold the depth itself.
  localparam int FILL_W      = $clog2(PULSE_SLOTS + 1);
  // The decode pointer starts at the 7-bit offset and runs one past the frame.
  localparam int PTR_W       = (FILL_W + 1 > 8) ? FILL_W + 1 : 8;

  localparam int TIME_W      = 32;
  localparam int CFG_W       = 20;
  localparam int OFFSET_W    = 7;
  localparam int CODE_W      = 32;
  localparam int CODE_BIT_W  = $clog2(CODE_W);
  localparam int COUNT_W     = 7;
  localparam int COUNT_MAX   = 127;
  localparam int CFG_IDX_W   = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_THR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_CEILING = 3'd5;

  // Register reset values.
  localparam logic [CFG_W-1:0]    NOISE_MIN_RST     = 20'd100;
  localparam logic [CFG_W-1:0]    NOISE_MAX_RST     = 20'd100000;
  localparam logic [OFFSET_W-1:0] OFFSET_RST        = 7'd2;
  localparam logic [CFG_W-1:0]    SYNC_THR_RST      = 20'd5000;
  localparam logic [CFG_W-1:0]    SHORT_FLOOR_RST   = 20'd550;
  localparam logic [CFG_W-1:0]    SHORT_CEILING_RST = 20'd1000;

  typedef struct packed {
    logic [CFG_W-1:0]    noise_min;
    logic [CFG_W-1:0]    noise_max;
    logic [OFFSET_W-1:0] offset;
    logic [CFG_W-1:0]    sync_thr;
    logic [CFG_W-1:0]    short_floor;
    logic [CFG_W-1:0]    short_ceiling;
  } cfg_t;

  // Commands handed from the classifier to the decode engine.
  typedef enum logic [0:0] {
    CMD_STORE = 1'b0,
    CMD_FRAME = 1'b1
  } cmd_op_t;

  // For a store, idx is the entry written; for a frame, it is the frame length.
  typedef struct packed {
    cmd_op_t           op;
    logic [FILL_W-1:0] idx;
    logic [TIME_W-1:0] dur;
  } cmd_t;

endpackage

[sv/ir_pulse_frame_decoder.sv]
// ----------------------------------------------------------------------------
// ir_pulse_frame_decoder
// Pulse-distance IR frame decoder: edge timestamps in, decoded words out.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     in_valid / in_stall  edge_time_us[31:0]
//  output    out_valid/out_stall  code[31:0], pulse_count[6:0]
//  config    cfg_we               cfg_index[2:0], cfg_data[19:0]
//
//  An edge that stores a duration is written to the store when its command is popped.
//  An edge that closes a frame starts a walk of that frame from the offset:
//  the store is read one pair per cycle through its two read ports.
//  A four-entry command queue lets edges be taken while a frame is decoded;
//  in_stall is high only while that queue is full.
//  Reset is synchronous; it clears the control state and loads the register
//  defaults. The store is not cleared, as every entry of a frame is written
//  before it is decoded.
// ----------------------------------------------------------------------------
module ir_pulse_frame_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [irpfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpfd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [irpfd_pkg::TIME_W-1:0]    edge_time_us,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [irpfd_pkg::CODE_W-1:0]    code,
  output logic [irpfd_pkg::COUNT_W-1:0]   pulse_count
);
  import irpfd_pkg::*;

  cfg_t cfg;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  cmd_t pop_cmd;
  logic q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise_min     <= NOISE_MIN_RST;
      cfg.noise_max     <= NOISE_MAX_RST;
      cfg.offset        <= OFFSET_RST;
      cfg.sync_thr      <= SYNC_THR_RST;
      cfg.short_floor   <= SHORT_FLOOR_RST;
      cfg.short_ceiling <= SHORT_CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOISE_MIN:     cfg.noise_min     <= cfg_data;
        REG_NOISE_MAX:     cfg.noise_max     <= cfg_data;
        REG_OFFSET:        cfg.offset        <= cfg_data[OFFSET_W-1:0];
        REG_SYNC_THR:      cfg.sync_thr      <= cfg_data;
        REG_SHORT_FLOOR:   cfg.short_floor   <= cfg_data;
        REG_SHORT_CEILING: cfg.short_ceiling <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  irpfd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .edge_time_us (edge_time_us),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  irpfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  irpfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_offset  (cfg.offset),
    .q_empty     (q_empty),
    .pop         (pop),
    .cmd         (pop_cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code        (code),
    .pulse_count (pulse_count)
  );

endmodule

[sv/irpfd_front.sv]
// ----------------------------------------------------------------------------
// irpfd_front
// Edge classifier: forms durations, filters noise, clamps short pulses and
// tracks frame filling, then issues store and frame commands.
// ----------------------------------------------------------------------------
module irpfd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  irpfd_pkg::cfg_t               cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [irpfd_pkg::TIME_W-1:0]  edge_time_us,
  input  logic                          q_full,
  output logic                          push,
  output irpfd_pkg::cmd_t               push_cmd
);
  import irpfd_pkg::*;

  localparam int PAD_W = TIME_W - CFG_W;

  logic [TIME_W-1:0] last_edge_time;
  logic [TIME_W-1:0] head_val;
  logic [FILL_W-1:0] fill_index;

  logic [TIME_W-1:0] dur;
  logic [TIME_W-1:0] d_lo;
  logic [TIME_W-1:0] d;
  logic [TIME_W-1:0] floor_x;
  logic [TIME_W-1:0] thr_x;
  logic              noise;
  logic              head_sync;
  logic              big;
  logic              full;
  logic              end_cond;
  logic              frame_end;
  logic              accept;
  logic [FILL_W-1:0] slot;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign floor_x = {{PAD_W{1'b0}}, cfg.short_floor};
  assign thr_x   = {{PAD_W{1'b0}}, cfg.sync_thr};

  assign dur   = edge_time_us - last_edge_time;
  assign noise = (dur < {{PAD_W{1'b0}}, cfg.noise_min}) ||
                 (dur > {{PAD_W{1'b0}}, cfg.noise_max});

  // Raise to the floor first, then snap a gap between floor and ceiling down to the floor.
  assign d_lo = (dur < floor_x) ? floor_x : dur;
  assign d    = ((d_lo > floor_x) && (d_lo < {{PAD_W{1'b0}}, cfg.short_ceiling}))
                ? floor_x : d_lo;

  assign head_sync = head_val > thr_x;
  assign big       = d > thr_x;
  assign full      = fill_index == FILL_W'(PULSE_SLOTS);
  assign end_cond  = head_sync && (big || full);
  assign frame_end = end_cond && (fill_index > FILL_W'(1));

  always_comb begin
    slot = fill_index;
    if (!end_cond && big) begin
      slot = '0;
    end
    if (slot == FILL_W'(PULSE_SLOTS)) begin
      slot = '0;
    end
  end

  assign push         = accept && !noise;
  assign push_cmd.op  = frame_end ? CMD_FRAME : CMD_STORE;
  assign push_cmd.idx = frame_end ? fill_index : slot;
  assign push_cmd.dur = d;

  // head_val mirrors entry 0 of the store, which decides whether a frame is open.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      head_val       <= '0;
      fill_index     <= '0;
    end else begin
      if (accept) begin
        last_edge_time <= edge_time_us;
      end
      if (push) begin
        if (frame_end) begin
          fill_index <= FILL_W'(1);
          head_val   <= d;
        end else begin
          fill_index <= slot + FILL_W'(1);
          if (slot == '0) begin
            head_val <= d;
          end
        end
      end
    end
  end

  fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill_index <= FILL_W'(PULSE_SLOTS))
    else $error("fill index beyond store depth");

  frame_len_ok: assert property (@(posedge clk) disable iff (rst)
    (push && push_cmd.op == CMD_FRAME) |=> (fill_index == FILL_W'(1)))
    else $error("fill index not restarted after frame end");

endmodule

[sv/irpfd_queue.sv]
// ----------------------------------------------------------------------------
// irpfd_queue
// Short command queue between the classifier and the decode engine.
// ----------------------------------------------------------------------------
module irpfd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  irpfd_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output irpfd_pkg::cmd_t pop_cmd,
  output logic            empty
);
  import irpfd_pkg::*;

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_cmd = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into a full command queue");

  no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from an empty command queue");

endmodule

[sv/irpfd_back.sv]
// ----------------------------------------------------------------------------
// irpfd_back
// Decode engine: owns the duration store, executes store commands and walks
// a completed frame one pair per cycle to build the code word.
// ----------------------------------------------------------------------------
module irpfd_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [irpfd_pkg::OFFSET_W-1:0]  cfg_offset,
  input  logic                            q_empty,
  output logic                            pop,
  input  irpfd_pkg::cmd_t                 cmd,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [irpfd_pkg::CODE_W-1:0]    code,
  output logic [irpfd_pkg::COUNT_W-1:0]   pulse_count
);
  import irpfd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DEC  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state;

  // Duration store with one write and two read ports.
  logic [TIME_W-1:0] pulse_mem [PULSE_SLOTS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [TIME_W-1:0] mem_wdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [TIME_W-1:0] rd_a;
  logic [TIME_W-1:0] rd_b;

  logic [PTR_W-1:0]   ptr;
  logic [PTR_W-1:0]   ptr_inc;
  logic [PTR_W-2:0]   k;
  logic [FILL_W-1:0]  len;
  logic [CODE_W-1:0]  code_acc;
  logic [TIME_W-1:0]  pend_d;
  logic               rd_valid;
  logic [PTR_W-2:0]   rd_k;
  logic               rd_b_zero;
  logic               b_zero;

  logic               issue;
  logic               fin_go;
  logic [TIME_W-1:0]  b_eff;
  logic               swap;
  logic [TIME_W-1:0]  lo;
  logic [TIME_W-1:0]  hi;
  logic               bit_set;

  assign pop     = (state == S_IDLE) && !q_empty;
  assign ptr_inc = ptr + PTR_W'(1);
  assign b_zero  = ptr_inc >= PTR_W'(PULSE_SLOTS);
  assign issue   = (state == S_DEC) && (ptr < PTR_W'(len));
  assign rd_en   = issue;
  assign rd_addr_a = ptr[ADDR_W-1:0];
  assign rd_addr_b = b_zero ? '0 : ptr_inc[ADDR_W-1:0];
  assign fin_go  = (state == S_FIN) && ((code_acc == '0) || !out_valid || !out_stall);

  // A pair whose first duration exceeds twice the second is taken swapped before the bit is decided.
  assign b_eff   = rd_b_zero ? '0 : rd_b;
  assign swap    = {b_eff, 1'b0} < {1'b0, rd_a};
  assign lo      = swap ? b_eff : rd_a;
  assign hi      = swap ? rd_a : b_eff;
  assign bit_set = {1'b0, hi} > {lo, 1'b0};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = cmd.dur;
    if (pop) begin
      mem_waddr = cmd.idx[ADDR_W-1:0];
      if (cmd.op == CMD_STORE) begin
        mem_we = 1'b1;
      end else begin
        // The closing duration is dropped when the frame fills the store.
        mem_we = cmd.idx < FILL_W'(PULSE_SLOTS);
      end
    end else if (fin_go) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = pend_d;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pulse_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a <= pulse_mem[rd_addr_a];
      rd_b <= pulse_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go && (code_acc != '0)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop && cmd.op == CMD_FRAME) begin
            ptr      <= PTR_W'(cfg_offset);
            k        <= '0;
            len      <= cmd.idx;
            pend_d   <= cmd.dur;
            code_acc <= '0;
            state    <= S_DEC;
          end
        end
        S_DEC: begin
          rd_valid <= issue;
          if (issue) begin
            rd_k      <= k;
            rd_b_zero <= b_zero;
            ptr       <= ptr + PTR_W'(2);
            k         <= k + (PTR_W - 1)'(1);
          end
          if (rd_valid && bit_set && (rd_k < (PTR_W - 1)'(CODE_W))) begin
            code_acc[rd_k[CODE_BIT_W-1:0]] <= 1'b1;
          end
          if (!issue && !rd_valid) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            if (code_acc != '0) begin
              code        <= code_acc;
              pulse_count <= (PTR_W'(len) > PTR_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                               : COUNT_W'(len);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  read_only_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state == S_DEC))
    else $error("pair data valid outside the frame walk");

  walk_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> !rd_valid)
    else $error("frame finished with a pair still in flight");

  code_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (code != '0))
    else $error("zero code presented as a result");

endmodule
